/* rtl/core/assert_macros.svh */
// Assertion macros shared by the command receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/core/cfrc_pkg.sv */
// Types, codes and the CRC-8 step of the command frame receiver.
package cfrc_pkg;

    // request types of an input word
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // command codes
    localparam logic [2:0] OP_SET_RING = 3'd0;
    localparam logic [2:0] OP_RESET    = 3'd1;
    localparam logic [2:0] OP_ARM      = 3'd2;
    localparam logic [2:0] OP_LED      = 3'd3;
    localparam logic [2:0] OP_STATUS   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_DEV_ADDR    = 3'd0;
    localparam logic [2:0] CFG_FW_VERSION  = 3'd1;
    localparam logic [2:0] CFG_OP_SET_RING = 3'd2;
    localparam logic [2:0] CFG_OP_RESET    = 3'd3;
    localparam logic [2:0] CFG_OP_ARM      = 3'd4;
    localparam logic [2:0] CFG_OP_LED      = 3'd5;
    localparam logic [2:0] CFG_OP_STATUS   = 3'd6;

    localparam logic [7:0] RST_OP_SET_RING = 8'd1;
    localparam logic [7:0] RST_OP_RESET    = 8'd2;
    localparam logic [7:0] RST_OP_ARM      = 8'd3;
    localparam logic [7:0] RST_OP_LED      = 8'd4;
    localparam logic [7:0] RST_OP_STATUS   = 8'd5;

    // read response codes
    localparam logic [7:0] RSP_FAILED = 8'h00;
    localparam logic [7:0] RSP_TAKEN  = 8'h01;

    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [5:0] FLAGS_MASK  = 6'h3F;
    // words that follow the response code of a status read
    localparam logic [2:0] BURST_LEN   = 3'd5;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data;
        logic       sieve_accepts;
        logic       sieve_armed;
        logic [7:0] sieve_modulus;
        logic [7:0] phase;
        logic [7:0] rst_cause;
    } t_in_word;

    typedef struct packed {
        logic       ack;
        logic       frame_ok;
        logic [7:0] read_data;
        logic       last;
        logic       led_on;
        logic       applied;
        logic [2:0] applied_op;
        logic [7:0] applied_phase;
    } t_out_word;

    typedef struct packed {
        logic [6:0] dev_addr;
        logic [7:0] fw_version;
        logic [7:0] op_set_ring;
        logic [7:0] op_reset;
        logic [7:0] op_arm;
        logic [7:0] op_led;
        logic [7:0] op_status;
    } t_cfg;

    // status read: phase, flags, modulus, version; byte 0 goes out first
    typedef struct packed {
        logic            start;
        logic [3:0][7:0] bytes;
    } t_burst;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/core/command_frame_receiver_crc8.sv */
// Bus target command receiver: a written byte, a stop or a read request enters per word; each
// written byte and each stop gives one result word in the next cycle, and a new word is taken
// every cycle while the output register drains. A read gives one word, or six after a taken
// status command: the response code comes with the request and the phase, flags, modulus,
// version and response CRC follow one per cycle from a five-word sequencer, which holds the
// input stalled until it is done (the words wait while the output side stalls). There is no
// clearing pass after reset.
`include "assert_macros.svh"

module command_frame_receiver_crc8
    import cfrc_pkg::*;
#(
    parameter int RING_BYTES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_cfg            r_cfg;
    logic            r_out_valid, n_out_valid;
    t_out_word       r_out_word, n_out_word;
    logic [2:0]      r_burst_left, n_burst_left;
    logic [3:0][7:0] r_rd_bytes, n_rd_bytes;
    logic [7:0]      r_rd_crc, n_rd_crc;

    logic      w_out_free;
    logic      w_in_take;
    t_out_word w_res;
    logic      w_has_res;
    t_burst    w_burst;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !(w_out_free && r_burst_left == '0);
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr    <= '0;
            r_cfg.fw_version  <= '0;
            r_cfg.op_set_ring <= RST_OP_SET_RING;
            r_cfg.op_reset    <= RST_OP_RESET;
            r_cfg.op_arm      <= RST_OP_ARM;
            r_cfg.op_led      <= RST_OP_LED;
            r_cfg.op_status   <= RST_OP_STATUS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DEV_ADDR:    r_cfg.dev_addr    <= i_cfg_wdata[6:0];
                CFG_FW_VERSION:  r_cfg.fw_version  <= i_cfg_wdata;
                CFG_OP_SET_RING: r_cfg.op_set_ring <= i_cfg_wdata;
                CFG_OP_RESET:    r_cfg.op_reset    <= i_cfg_wdata;
                CFG_OP_ARM:      r_cfg.op_arm      <= i_cfg_wdata;
                CFG_OP_LED:      r_cfg.op_led      <= i_cfg_wdata;
                CFG_OP_STATUS:   r_cfg.op_status   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    cfrc_frame #(
        .RING_BYTES(RING_BYTES)
    ) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_in_take),
        .i_word   (i_in_word),
        .i_cfg    (r_cfg),
        .o_res    (w_res),
        .o_has_res(w_has_res),
        .o_burst  (w_burst)
    );

    // output register and status read sequencer
    always_comb begin
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_word   = r_out_word;
        n_burst_left = r_burst_left;
        n_rd_bytes   = r_rd_bytes;
        n_rd_crc     = r_rd_crc;

        if (w_in_take && w_has_res) begin
            n_out_valid = 1'b1;
            n_out_word  = w_res;
            if (w_burst.start) begin
                n_burst_left = BURST_LEN;
                n_rd_bytes   = w_burst.bytes;
                n_rd_crc     = crc8_step(8'h00, {r_cfg.dev_addr, 1'b1});
            end
        end else if (r_burst_left != '0 && w_out_free) begin
            n_out_valid          = 1'b1;
            n_out_word           = '0;
            n_out_word.led_on    = r_out_word.led_on;
            n_burst_left         = r_burst_left - 3'd1;
            if (r_burst_left == 3'd1) begin
                n_out_word.read_data = r_rd_crc;
                n_out_word.last      = 1'b1;
            end else begin
                n_out_word.read_data = r_rd_bytes[0];
                n_rd_crc             = crc8_step(r_rd_crc, r_rd_bytes[0]);
                n_rd_bytes           = {8'h00, r_rd_bytes[3:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_burst_left <= '0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_burst_left <= n_burst_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_rd_bytes <= n_rd_bytes;
        r_rd_crc   <= n_rd_crc;
    end

    `ASSERT_CLK(a_no_take_in_burst, (r_burst_left != 3'd0) |-> o_in_stall,
        "word taken during status burst")
    `ASSERT_CLK(a_burst_from_read,
        (r_burst_left == BURST_LEN && $past(r_burst_left) != BURST_LEN) |->
            $past(w_in_take && i_in_word.req_type == REQ_READ),
        "status burst without read")
    `ASSERT_CLK(a_last_ends_burst, (o_out_valid && o_out_word.last) |-> (r_burst_left == 3'd0),
        "last word while burst pending")
    `ASSERT_CLK(a_ack_not_stop, !(o_out_valid && o_out_word.ack && o_out_word.frame_ok),
        "ack and frame_ok in one word")

endmodule

/* rtl/core/cfrc_frame.sv */
// Frame decoder: opcode, payload, CRC check, command effects and first result word.
module cfrc_frame
    import cfrc_pkg::*;
#(
    parameter int RING_BYTES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_res,
    output logic      o_has_res,
    output t_burst    o_burst
);

    localparam int IDX_W = $clog2(RING_BYTES + 4);
    localparam logic [IDX_W-1:0] LEN_RING = IDX_W'(RING_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

    logic [7:0]       r_crc, n_crc;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [2:0]       r_cur_op, n_cur_op;
    logic [7:0]       r_pay0, n_pay0;
    logic             r_nack, n_nack;
    logic             r_acc, n_acc;
    logic             r_led, n_led;
    logic [2:0]       r_done_op, n_done_op;
    logic             r_last_taken, n_last_taken;

    logic             w_op_hit;
    logic [2:0]       w_op;
    logic [IDX_W-1:0] w_len;
    logic             w_cmd_ok;
    logic             w_led_chg;
    logic             w_led_val;
    logic             w_stop_ok;

    // first matching opcode wins
    always_comb begin
        w_op_hit = 1'b1;
        w_op     = OP_SET_RING;
        if (i_word.data == i_cfg.op_set_ring) begin
            w_op = OP_SET_RING;
        end else if (i_word.data == i_cfg.op_reset) begin
            w_op = OP_RESET;
        end else if (i_word.data == i_cfg.op_arm) begin
            w_op = OP_ARM;
        end else if (i_word.data == i_cfg.op_led) begin
            w_op = OP_LED;
        end else if (i_word.data == i_cfg.op_status) begin
            w_op = OP_STATUS;
        end else begin
            w_op_hit = 1'b0;
        end
    end

    always_comb begin
        case (r_cur_op) inside
            OP_SET_RING:    w_len = LEN_RING;
            OP_ARM, OP_LED: w_len = IDX_ONE;
            default:        w_len = '0;
        endcase
    end

    always_comb begin
        w_cmd_ok  = 1'b0;
        w_led_chg = 1'b0;
        w_led_val = 1'b0;
        case (r_cur_op) inside
            OP_SET_RING, OP_ARM: w_cmd_ok = i_word.sieve_accepts;
            OP_RESET: begin
                w_cmd_ok  = 1'b1;
                w_led_chg = 1'b1;
            end
            OP_LED: begin
                w_cmd_ok  = !i_word.sieve_armed;
                w_led_chg = !i_word.sieve_armed;
                w_led_val = (r_pay0 != 8'h00);
            end
            OP_STATUS: w_cmd_ok = 1'b1;
            default:   w_cmd_ok = 1'b0;
        endcase
    end

    assign w_stop_ok = r_acc && !r_nack;

    always_comb begin
        n_crc        = r_crc;
        n_idx        = r_idx;
        n_cur_op     = r_cur_op;
        n_pay0       = r_pay0;
        n_nack       = r_nack;
        n_acc        = r_acc;
        n_led        = r_led;
        n_done_op    = r_done_op;
        n_last_taken = r_last_taken;
        o_res        = '0;
        o_has_res    = 1'b0;
        o_burst      = '0;

        if (i_take) begin
            unique case (i_word.req_type)
                REQ_WRITE: begin
                    o_has_res = 1'b1;
                    if (!r_nack) begin
                        if (r_idx == '0) begin
                            if (w_op_hit) begin
                                n_cur_op  = w_op;
                                n_crc     = crc8_step(crc8_step(8'h00, {i_cfg.dev_addr, 1'b0}),
                                                      i_word.data);
                                n_idx     = IDX_ONE;
                                o_res.ack = 1'b1;
                            end else begin
                                n_nack = 1'b1;
                            end
                        end else if (r_idx <= w_len) begin
                            if (r_idx == IDX_ONE) begin
                                n_pay0 = i_word.data;
                            end
                            n_crc     = crc8_step(r_crc, i_word.data);
                            n_idx     = r_idx + IDX_ONE;
                            o_res.ack = 1'b1;
                        end else if (r_idx == w_len + IDX_ONE) begin
                            n_idx = r_idx + IDX_ONE;
                            // the sieve verdict only counts when the CRC matches
                            if (i_word.data == r_crc && w_cmd_ok) begin
                                if (w_led_chg) begin
                                    n_led = w_led_val;
                                end
                                n_acc               = 1'b1;
                                n_done_op           = r_cur_op;
                                o_res.ack           = 1'b1;
                                o_res.applied       = 1'b1;
                                o_res.applied_op    = r_cur_op;
                                o_res.applied_phase = (r_cur_op == OP_ARM) ? r_pay0 : 8'h00;
                            end else begin
                                n_nack = 1'b1;
                            end
                        end else begin
                            n_nack = 1'b1;
                        end
                    end
                end
                REQ_STOP: begin
                    o_has_res      = 1'b1;
                    o_res.frame_ok = w_stop_ok;
                    n_last_taken   = w_stop_ok;
                    n_idx          = '0;
                    n_cur_op       = OP_SET_RING;
                    n_nack         = 1'b0;
                    n_acc          = 1'b0;
                end
                REQ_READ: begin
                    o_has_res = 1'b1;
                    if (!r_last_taken || r_done_op != OP_STATUS) begin
                        o_res.read_data = r_last_taken ? RSP_TAKEN : RSP_FAILED;
                        o_res.last      = 1'b1;
                    end else begin
                        o_res.read_data   = RSP_TAKEN;
                        o_burst.start     = 1'b1;
                        o_burst.bytes[0]  = i_word.phase;
                        o_burst.bytes[1]  = {1'b0, i_word.sieve_armed,
                                             i_word.rst_cause[5:0] & FLAGS_MASK};
                        o_burst.bytes[2]  = i_word.sieve_modulus;
                        o_burst.bytes[3]  = i_cfg.fw_version;
                    end
                end
                default: ;
            endcase
        end
        o_res.led_on = n_led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_cur_op     <= OP_SET_RING;
            r_nack       <= 1'b0;
            r_acc        <= 1'b0;
            r_led        <= 1'b0;
            r_done_op    <= OP_SET_RING;
            r_last_taken <= 1'b0;
        end else begin
            r_idx        <= n_idx;
            r_cur_op     <= n_cur_op;
            r_nack       <= n_nack;
            r_acc        <= n_acc;
            r_led        <= n_led;
            r_done_op    <= n_done_op;
            r_last_taken <= n_last_taken;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc  <= n_crc;
        r_pay0 <= n_pay0;
    end

endmodule

/* test/command_frame_receiver_crc8_tb.sv */
// Self-checking testbench of the CRC-8 command frame receiver.
module command_frame_receiver_crc8_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cfrc_pkg::*;

    localparam int RING_BYTES    = 16;
    localparam int BODY_MAX      = RING_BYTES + 1;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 8;
    localparam int WATCHDOG_MAX  = 2000;
    localparam logic [1:0] REQ_NONE   = 2'd3;
    localparam logic [2:0] OP_UNKNOWN = 3'd7;

    typedef enum int {FR_GOOD, FR_BAD_CRC, FR_EXTRA, FR_SHORT} t_frame_kind;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [2:0] cfg_addr = '0;
    logic [7:0] cfg_wdata = '0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // receiver copy: configuration
    logic [6:0] cfg_dev_addr = '0;
    logic [7:0] cfg_fw_version = '0;
    logic [7:0] opcode_of [0:4] = '{RST_OP_SET_RING, RST_OP_RESET, RST_OP_ARM,
                                     RST_OP_LED, RST_OP_STATUS};
    // receiver copy: frame and command state
    logic [7:0] run_crc = '0;
    int         byte_idx = 0;
    logic [2:0] cur_op = OP_SET_RING;
    logic [7:0] body [0:BODY_MAX-1];
    logic       nack_latched = 1'b0;
    logic       frame_accepted = 1'b0;
    logic       led_lit = 1'b0;
    logic [2:0] done_op = OP_SET_RING;
    logic [7:0] done_phase = '0;
    logic       last_taken = 1'b0;

    t_out_word pending_replies [$];
    int        fails = 0;
    int        items_sent = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    bit        hold_req = 1'b0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    command_frame_receiver_crc8 #(.RING_BYTES(RING_BYTES)) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #6 clk = ~clk;

    // MSB-first bit-serial form of the 0x07 polynomial
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[7] ^ b[k];
            r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // lowest command code wins on duplicate opcode bytes
    function automatic logic [2:0] decode_opcode(input logic [7:0] b);
        if (b == opcode_of[OP_SET_RING]) return OP_SET_RING;
        if (b == opcode_of[OP_RESET]) return OP_RESET;
        if (b == opcode_of[OP_ARM]) return OP_ARM;
        if (b == opcode_of[OP_LED]) return OP_LED;
        if (b == opcode_of[OP_STATUS]) return OP_STATUS;
        return OP_UNKNOWN;
    endfunction

    function automatic int body_len(input logic [2:0] op);
        case (op)
            OP_SET_RING: return BODY_MAX;
            OP_ARM, OP_LED: return 1;
            default: return 0;
        endcase
    endfunction

    // advance the receiver copy by one accepted word, queue the replies it gives
    task automatic frame_receiver_step(input t_in_word w);
        t_out_word  r;
        logic [7:0] burst [0:4];
        logic [7:0] crc;
        logic [2:0] op;
        logic       ok;
        int         len;
        r = '0;
        case (w.req_type)
            REQ_WRITE: begin
                len = body_len(cur_op);
                if (nack_latched) begin
                end else if (byte_idx == 0) begin
                    op = decode_opcode(w.data);
                    if (op == OP_UNKNOWN) begin
                        nack_latched = 1'b1;
                    end else begin
                        cur_op = op;
                        run_crc = crc8_next(crc8_next(8'h00, {cfg_dev_addr, 1'b0}), w.data);
                        byte_idx = 1;
                        r.ack = 1'b1;
                    end
                end else if (byte_idx <= len) begin
                    body[byte_idx - 1] = w.data;
                    run_crc = crc8_next(run_crc, w.data);
                    byte_idx++;
                    r.ack = 1'b1;
                end else if (byte_idx == len + 1) begin
                    byte_idx++;
                    ok = (w.data == run_crc);
                    // sieve verdict only matters once the CRC matched
                    if (ok) begin
                        case (cur_op)
                            OP_SET_RING, OP_ARM: ok = w.sieve_accepts;
                            OP_RESET: led_lit = 1'b0;
                            OP_LED: begin
                                if (w.sieve_armed) ok = 1'b0;
                                else led_lit = (body[0] != 8'h00);
                            end
                            default: ;
                        endcase
                    end
                    if (!ok) begin
                        nack_latched = 1'b1;
                    end else begin
                        frame_accepted = 1'b1;
                        done_op = cur_op;
                        done_phase = (cur_op == OP_ARM) ? body[0] : 8'h00;
                        r.ack = 1'b1;
                        r.applied = 1'b1;
                        r.applied_op = done_op;
                        r.applied_phase = done_phase;
                    end
                end else begin
                    nack_latched = 1'b1;
                end
                r.led_on = led_lit;
                pending_replies.push_back(r);
            end
            REQ_STOP: begin
                last_taken = frame_accepted && !nack_latched;
                byte_idx = 0;
                cur_op = OP_SET_RING;
                nack_latched = 1'b0;
                frame_accepted = 1'b0;
                r.frame_ok = last_taken;
                r.led_on = led_lit;
                pending_replies.push_back(r);
            end
            REQ_READ: begin
                r.led_on = led_lit;
                if (!last_taken || done_op != OP_STATUS) begin
                    r.read_data = last_taken ? RSP_TAKEN : RSP_FAILED;
                    r.last = 1'b1;
                    pending_replies.push_back(r);
                end else begin
                    r.read_data = RSP_TAKEN;
                    pending_replies.push_back(r);
                    burst[0] = w.phase;
                    burst[1] = {1'b0, w.sieve_armed, w.rst_cause[5:0]};
                    burst[2] = w.sieve_modulus;
                    burst[3] = cfg_fw_version;
                    crc = crc8_next(8'h00, {cfg_dev_addr, 1'b1});
                    for (int i = 0; i < 4; i++) crc = crc8_next(crc, burst[i]);
                    burst[4] = crc;
                    for (int i = 0; i < 5; i++) begin
                        r.read_data = burst[i];
                        r.last = (i == 4);
                        pending_replies.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // offer one word, wait for the handshake, then maybe go idle
    task automatic send_word(input logic [1:0] req, input logic [7:0] d,
                             input logic acc, input logic arm);
        t_in_word w;
        w.req_type = req;
        w.data = d;
        w.sieve_accepts = acc;
        w.sieve_armed = arm;
        w.sieve_modulus = 8'($urandom);
        w.phase = 8'($urandom);
        w.rst_cause = 8'($urandom);
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        frame_receiver_step(w);
        if (req != REQ_NONE) items_sent++;
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic send_frame(input logic [2:0] op, input t_frame_kind kind,
                              input logic [7:0] body0, input logic verdict,
                              input logic armed_now);
        logic [7:0] crc;
        logic [7:0] b;
        crc = crc8_next(crc8_next(8'h00, {cfg_dev_addr, 1'b0}), opcode_of[op]);
        send_word(REQ_WRITE, opcode_of[op], 1'($urandom), 1'($urandom));
        for (int i = 0; i < body_len(op); i++) begin
            b = (i == 0) ? body0 : 8'($urandom);
            crc = crc8_next(crc, b);
            send_word(REQ_WRITE, b, 1'($urandom), 1'($urandom));
        end
        if (kind != FR_SHORT) begin
            if (kind == FR_BAD_CRC) crc ^= 8'(1 << $urandom_range(7));
            send_word(REQ_WRITE, crc, verdict, armed_now);
        end
        if (kind == FR_EXTRA) send_word(REQ_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
        send_word(REQ_STOP, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // sender goes quiet until every reply is back, then lets the tail settle
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_DEV_ADDR: cfg_dev_addr = val[6:0];
            CFG_FW_VERSION: cfg_fw_version = val;
            CFG_OP_SET_RING: opcode_of[OP_SET_RING] = val;
            CFG_OP_RESET: opcode_of[OP_RESET] = val;
            CFG_OP_ARM: opcode_of[OP_ARM] = val;
            CFG_OP_LED: opcode_of[OP_LED] = val;
            CFG_OP_STATUS: opcode_of[OP_STATUS] = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] addr, input logic [7:0] fw,
                              input logic [7:0] s, input logic [7:0] r, input logic [7:0] a,
                              input logic [7:0] l, input logic [7:0] st);
        write_reg(CFG_DEV_ADDR, addr);
        write_reg(CFG_FW_VERSION, fw);
        write_reg(CFG_OP_SET_RING, s);
        write_reg(CFG_OP_RESET, r);
        write_reg(CFG_OP_ARM, a);
        write_reg(CFG_OP_LED, l);
        write_reg(CFG_OP_STATUS, st);
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed frames, some broken ones and loose noise
    task automatic random_traffic(input int n);
        int         stop_at;
        int         pick;
        logic [2:0] op;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            case ($urandom_range(8))
                0: op = OP_SET_RING;
                1, 2: op = OP_RESET;
                3, 4: op = OP_ARM;
                5, 6: op = OP_LED;
                default: op = OP_STATUS;
            endcase
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_frame(op, FR_GOOD, $urandom_range(1) ? 8'($urandom) : 8'h00,
                           $urandom_range(3) != 0, $urandom_range(3) == 0);
                if ($urandom_range(1))
                    send_word(REQ_READ, 8'($urandom), 1'($urandom), 1'($urandom));
            end else if (pick < 78) begin
                send_frame(op, FR_BAD_CRC, 8'($urandom), 1'b1, 1'b0);
            end else if (pick < 84) begin
                send_frame(op, FR_EXTRA, 8'($urandom), 1'b1, 1'b0);
            end else if (pick < 90) begin
                send_frame(op, FR_SHORT, 8'($urandom), 1'b1, 1'b0);
            end else if (pick < 96) begin
                repeat (3) send_word(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                send_word(REQ_READ, 8'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        // nothing taken yet: single failed code, empty frame not ok
        send_word(REQ_READ, 8'h00, 1'b0, 1'b0);
        send_word(REQ_STOP, 8'hFF, 1'b1, 1'b1);
        send_word(REQ_NONE, 8'hA5, 1'b1, 1'b0);
        // unknown opcode, nack holds until stop
        send_word(REQ_WRITE, 8'h00, 1'b1, 1'b0);
        send_word(REQ_WRITE, opcode_of[OP_RESET], 1'b1, 1'b0);
        send_word(REQ_STOP, 8'h00, 1'b0, 1'b0);
        send_frame(OP_STATUS, FR_GOOD, 8'h00, 1'b1, 1'b0);
        send_word(REQ_READ, 8'h00, 1'b0, 1'b1);
        send_frame(OP_LED, FR_GOOD, 8'hFF, 1'b0, 1'b0);
        // led refused while armed
        send_frame(OP_LED, FR_GOOD, 8'h00, 1'b1, 1'b1);
        send_frame(OP_ARM, FR_GOOD, 8'hFF, 1'b1, 1'b1);
        send_frame(OP_ARM, FR_GOOD, 8'h00, 1'b0, 1'b0);
        send_frame(OP_RESET, FR_BAD_CRC, 8'h00, 1'b1, 1'b0);
        send_frame(OP_RESET, FR_EXTRA, 8'h00, 1'b1, 1'b0);
        send_word(REQ_READ, 8'hFF, 1'b1, 1'b0);
    endtask

    task automatic test_extreme_settings();
        quiesce();
        set_config(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01);
        random_traffic(35);
    endtask

    task automatic test_output_hold_off();
        quiesce();
        idle_pct = 0;
        stall_pct = 0;
        send_frame(OP_STATUS, FR_GOOD, 8'h00, 1'b1, 1'b0);
        hold_req = 1'b1;
        repeat (12) send_word(REQ_READ, 8'($urandom), 1'($urandom), 1'($urandom));
        quiesce();
        random_traffic(20);
    endtask

    task automatic test_sender_idle();
        quiesce();
        set_config(8'h00, 8'h00, 8'hFF, 8'h00, 8'h40, 8'h20, 8'hFE);
        idle_pct = 82;
        stall_pct = 0;
        random_traffic(35);
    endtask

    task automatic test_receiver_stall();
        quiesce();
        // arm shares set-ring's byte, status shares led's byte
        set_config(8'($urandom), 8'($urandom), 8'h11, 8'h22, 8'h11, 8'h33, 8'h33);
        idle_pct = 0;
        stall_pct = 82;
        random_traffic(35);
    endtask

    task automatic test_both_idle();
        quiesce();
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
        idle_pct = 20;
        stall_pct = 20;
        random_traffic(35);
    endtask

    // output stall: long hold-off on request, otherwise random
    always @(posedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk) begin : reply_check
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_replies.size() == 0) begin
                $error("result word with nothing pending: %h", out_word);
                fails++;
            end else begin
                want = pending_replies.pop_front();
                compare_field("ack", want.ack, out_word.ack);
                compare_field("frame_ok", want.frame_ok, out_word.frame_ok);
                compare_field("read_data", want.read_data, out_word.read_data);
                compare_field("last", want.last, out_word.last);
                compare_field("led_on", want.led_on, out_word.led_on);
                compare_field("applied", want.applied, out_word.applied);
                compare_field("applied_op", want.applied_op, out_word.applied_op);
                compare_field("applied_phase", want.applied_phase, out_word.applied_phase);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_extreme_settings();
        test_output_hold_off();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        quiesce();
        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cfrc_pkg.sv
rtl/core/cfrc_frame.sv
rtl/core/command_frame_receiver_crc8.sv
test/command_frame_receiver_crc8_tb.sv
